/* rtl/core/ssdg_pkg.sv */
// ssdg_pkg: types, constants and codes of the step/direction generator
// depends on nothing; used by the interfaces and every module in rtl/core
package ssdg_pkg;

    localparam int PERIOD_WIDTH = 19;

    localparam int RATE_W   = 20;
    localparam int LIMIT_W  = 19;
    localparam int SPEED_W  = 21;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    // quotient compare width, wide enough for the quotient and the period
    localparam int CMP_W = (PERIOD_WIDTH > RATE_W) ? PERIOD_WIDTH : RATE_W;
    localparam logic [CMP_W-1:0] PERIOD_LIM = CMP_W'((64'd1 << PERIOD_WIDTH) - 64'd1);

    localparam logic [RATE_W-1:0]  TICK_RATE_RST  = RATE_W'(250000);
    localparam logic [LIMIT_W-1:0] MIN_PERIOD_RST = LIMIT_W'(5);
    localparam logic [LIMIT_W-1:0] MAX_PERIOD_RST = LIMIT_W'(500000);
    localparam logic [CMP_W-1:0]   MAX_PERIOD_EXT = CMP_W'(MAX_PERIOD_RST);
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RST =
        (MAX_PERIOD_EXT > PERIOD_LIM) ? PERIOD_WIDTH'(PERIOD_LIM)
                                      : PERIOD_WIDTH'(MAX_PERIOD_EXT);

    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SPEED = 2'd1;
    localparam logic [1:0] MODE_ZERO  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SPEED,
        OP_ZERO,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               dir_ccw;
        logic [SPEED_W-1:0] divisor;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef enum logic [1:0] {
        S_READY,
        S_DIVIDE,
        S_FINISH
    } t_back_state;

endpackage

/* rtl/core/ssdg_if.sv */
// ssdg channel interfaces: command items, result items, configuration writes
// depends on ssdg_pkg
interface ssdg_in_if import ssdg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic signed [SPEED_W-1:0]  speed_command;

    modport source (output valid, mode, speed_command, input ready);
    modport sink   (input valid, mode, speed_command, output ready);
endinterface

interface ssdg_out_if import ssdg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     step_level;
    logic                     dir_level;
    logic signed [POS_W-1:0]  step_position;

    modport source (output valid, step_level, dir_level, step_position, input ready);
    modport sink   (input valid, step_level, dir_level, step_position, output ready);
endinterface

interface ssdg_cfg_if import ssdg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/stepper_step_dir_generator.sv */
// stepper_step_dir_generator: top level of the one-motor step/direction generator
// depends on ssdg_pkg, ssdg_if, ssdg_front, ssdg_queue and ssdg_back
//
// Channels: i_item takes commands (mode 0 tick, 1 set speed, 2 zero the
// position, 3 no change); o_result gives one transaction per command with the
// step pin, direction pin and signed position after that command; i_cfg writes
// tick_rate (index 0), min_period (1) and max_period (2), always ready.
// Commands enter a two-entry queue; the back end runs them in order.
// Tick, zero and no-change commands run in the back end's ready state and
// sustain one per cycle while o_result does not stall; each goes from the
// queue into the result register. A set-speed command passes the divide and
// finish states of the restoring divider that produces one quotient bit per
// cycle over 20 bits of tick_rate. When o_result stalls, the result register
// holds; the queue fills and then i_item.ready drops. Nothing is dropped.
// Reset (synchronous, active low) restores the register defaults, the period
// to max_period, the position and counter to zero, step pin high and
// direction pin low, and empties the queue and the result register.
module stepper_step_dir_generator import ssdg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssdg_in_if.sink     i_item,
    ssdg_cfg_if.sink    i_cfg,
    ssdg_out_if.source  o_result
);

    t_q_stat w_q_stat;
    t_cmd    w_push_cmd;
    t_cmd    w_head_cmd;
    logic    w_push;
    logic    w_pop;

    ssdg_front u_front (
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    ssdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_cmd   (w_head_cmd)
    );

    ssdg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .i_cfg    (i_cfg),
        .o_res    (o_result)
    );

endmodule

/* rtl/core/ssdg_front.sv */
// ssdg_front: accepts command items and classifies them into queue entries
// depends on ssdg_pkg and ssdg_in_if
module ssdg_front import ssdg_pkg::*; (
    ssdg_in_if.sink   i_item,
    input  t_q_stat   i_q_stat,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [SPEED_W-1:0] w_raw;
    logic [SPEED_W-1:0] w_mag;

    assign i_item.ready = !i_q_stat.full;
    assign o_push       = i_item.valid && !i_q_stat.full;

    assign w_raw = i_item.speed_command;
    assign w_mag = w_raw[SPEED_W-1] ? (~w_raw + SPEED_W'(1)) : w_raw;

    always_comb begin
        case (i_item.mode)
            MODE_TICK:  o_cmd.op = OP_TICK;
            MODE_SPEED: o_cmd.op = OP_SPEED;
            MODE_ZERO:  o_cmd.op = OP_ZERO;
            default:    o_cmd.op = OP_NONE;
        endcase
        o_cmd.dir_ccw = w_raw[SPEED_W-1];
        o_cmd.divisor = w_mag + SPEED_W'(1);
    end

endmodule

/* rtl/core/ssdg_queue.sv */
// ssdg_queue: short command queue between front and back
// depends on ssdg_pkg
module ssdg_queue import ssdg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd     i_cmd,
    input  logic     i_pop,
    output t_q_stat  o_stat,
    output t_cmd     o_cmd
);

    t_cmd            r_entry [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_cmd        = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/core/ssdg_back.sv */
// ssdg_back: executes queued commands, holds the motor state, the settings
// registers, the iterative period divider and the result register; uses ssdg_pkg
module ssdg_back import ssdg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    ssdg_cfg_if.sink   i_cfg,
    ssdg_out_if.source o_res
);

    t_back_state r_state;
    t_back_state n_state;

    logic [RATE_W-1:0]  r_tick_rate;
    logic [LIMIT_W-1:0] r_min_period;
    logic [LIMIT_W-1:0] r_max_period;

    logic                    r_dir_ccw;
    logic [PERIOD_WIDTH-1:0] r_period;
    logic [PERIOD_WIDTH-1:0] r_tick_cnt;
    logic [POS_W-1:0]        r_position;
    logic                    r_step_pin;
    logic                    r_dir_pin;

    logic                    n_dir_ccw;
    logic [PERIOD_WIDTH-1:0] n_period;
    logic [PERIOD_WIDTH-1:0] n_tick_cnt;
    logic [POS_W-1:0]        n_position;
    logic                    n_step_pin;
    logic                    n_dir_pin;

    logic [SPEED_W-1:0]   r_divisor;
    logic [SPEED_W-1:0]   r_rem;
    logic [RATE_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_step_cnt;
    logic                 r_new_dir;

    logic                 r_out_valid;
    logic                 r_out_step;
    logic                 r_out_dir;
    logic [POS_W-1:0]     r_out_pos;

    logic                 w_out_free;
    logic                 w_exec;
    logic                 w_start;
    logic                 w_div_done;
    logic [SPEED_W:0]     w_trial;
    logic                 w_fits;
    logic [CMP_W-1:0]     w_quo;
    logic [CMP_W-1:0]     w_min;
    logic [CMP_W-1:0]     w_max;
    logic [CMP_W-1:0]     w_clamp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate  <= TICK_RATE_RST;
            r_min_period <= MIN_PERIOD_RST;
            r_max_period <= MAX_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TICK_RATE:  r_tick_rate  <= i_cfg.data[RATE_W-1:0];
                CFG_MIN_PERIOD: r_min_period <= i_cfg.data[LIMIT_W-1:0];
                CFG_MAX_PERIOD: r_max_period <= i_cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_READY: begin
                if (i_q_stat.valid && i_cmd.op == OP_SPEED) begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (r_step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_READY;
                end
            end
            default: n_state = S_READY;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_exec     = 1'b0;
        w_start    = 1'b0;
        w_div_done = 1'b0;
        case (r_state)
            S_READY: begin
                w_start = i_q_stat.valid && i_cmd.op == OP_SPEED;
                w_exec  = i_q_stat.valid && i_cmd.op != OP_SPEED && w_out_free;
            end
            S_FINISH: w_div_done = w_out_free;
            default: ;
        endcase
    end

    assign o_pop = w_exec || w_start;

    // restoring division step
    assign w_trial = {r_rem, r_quo[RATE_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    assign w_quo   = CMP_W'(r_quo);
    assign w_min   = CMP_W'(r_min_period);
    assign w_max   = CMP_W'(r_max_period);

    always_comb begin
        if (w_quo > w_max) begin
            w_clamp = w_max;
        end else if (w_quo < w_min) begin
            w_clamp = w_min;
        end else begin
            w_clamp = w_quo;
        end
        if (w_clamp > PERIOD_LIM) begin
            w_clamp = PERIOD_LIM;
        end
    end

    always_comb begin
        n_dir_ccw  = r_dir_ccw;
        n_period   = r_period;
        n_tick_cnt = r_tick_cnt;
        n_position = r_position;
        n_step_pin = r_step_pin;
        n_dir_pin  = r_dir_pin;
        if (w_div_done) begin
            n_dir_ccw = r_new_dir;
            n_period  = PERIOD_WIDTH'(w_clamp);
        end
        if (w_exec) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_tick_cnt >= r_period) begin
                        n_tick_cnt = '0;
                        n_step_pin = 1'b1;
                        n_position = r_dir_ccw ? r_position - POS_W'(1)
                                               : r_position + POS_W'(1);
                    end else if (r_tick_cnt == PERIOD_WIDTH'(1)) begin
                        n_step_pin = 1'b0;
                        n_dir_pin  = r_dir_ccw;
                    end
                    n_tick_cnt = n_tick_cnt + PERIOD_WIDTH'(1);
                end
                OP_ZERO: n_position = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_dir_ccw   <= 1'b0;
            r_period    <= PERIOD_RST;
            r_tick_cnt  <= '0;
            r_position  <= '0;
            r_step_pin  <= 1'b1;
            r_dir_pin   <= 1'b0;
            r_step_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dir_ccw  <= n_dir_ccw;
            r_period   <= n_period;
            r_tick_cnt <= n_tick_cnt;
            r_position <= n_position;
            r_step_pin <= n_step_pin;
            r_dir_pin  <= n_dir_pin;
            if (w_start) begin
                r_step_cnt <= '0;
            end else if (r_state == S_DIVIDE) begin
                r_step_cnt <= r_step_cnt + DIV_CNT_W'(1);
            end
            if (w_exec || w_div_done) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_divisor <= i_cmd.divisor;
            r_new_dir <= i_cmd.dir_ccw;
            r_rem     <= '0;
            r_quo     <= r_tick_rate;
        end else if (r_state == S_DIVIDE) begin
            r_rem <= w_fits ? SPEED_W'(w_trial - {1'b0, r_divisor}) : SPEED_W'(w_trial);
            r_quo <= {r_quo[RATE_W-2:0], w_fits};
        end
        if (w_exec || w_div_done) begin
            r_out_step <= n_step_pin;
            r_out_dir  <= n_dir_pin;
            r_out_pos  <= n_position;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.step_level    = r_out_step;
    assign o_res.dir_level     = r_out_dir;
    assign o_res.step_position = r_out_pos;

    a_fire_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_cmd.op == OP_TICK && r_tick_cnt >= r_period)
        |=> (r_step_pin && r_tick_cnt == PERIOD_WIDTH'(1)))
        else $error("step fire did not restart the counter");

    a_position_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_exec && (i_cmd.op == OP_TICK || i_cmd.op == OP_ZERO))
        |=> $stable(r_position))
        else $error("position moved without a tick or zero command");

    a_period_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_div_done |=> $stable(r_period))
        else $error("period changed outside a finished division");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> ##(DIV_STEPS) (r_state == S_FINISH))
        else $error("division did not take the expected number of steps");

endmodule

/* tb/tb_stepper_step_dir_generator.sv */
// testbench for stepper_step_dir_generator: directed and random command streams,
// checked per transaction against a scoreboard that tracks pins, period and position
// depends on ssdg_pkg, ssdg_if and the rtl/core sources
`timescale 1ns / 1ps

module tb_stepper_step_dir_generator;
    import ssdg_pkg::*;

    localparam int unsigned PERIOD_CAP = 32'((64'd1 << PERIOD_WIDTH) - 64'd1);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 265;

    typedef struct packed {
        logic             step;
        logic             dir;
        logic [POS_W-1:0] pos;
    } t_pin_state;

    class step_scoreboard;
        logic [RATE_W-1:0]       tick_rate;
        logic [LIMIT_W-1:0]      min_period;
        logic [LIMIT_W-1:0]      max_period;
        logic                    dir_ccw;
        logic [PERIOD_WIDTH-1:0] period;
        logic [PERIOD_WIDTH-1:0] tick_cnt;
        logic [POS_W-1:0]        position;
        logic                    step_pin;
        logic                    dir_pin;
        t_pin_state              expected_pins[$];
        int                      errors;

        function new();
            tick_rate  = TICK_RATE_RST;
            min_period = MIN_PERIOD_RST;
            max_period = MAX_PERIOD_RST;
            dir_ccw    = 1'b0;
            period     = cap_period(max_period);
            tick_cnt   = '0;
            position   = '0;
            step_pin   = 1'b1;
            dir_pin    = 1'b0;
            errors     = 0;
        endfunction

        function logic [PERIOD_WIDTH-1:0] cap_period(int unsigned q);
            return (q > PERIOD_CAP) ? PERIOD_WIDTH'(PERIOD_CAP) : PERIOD_WIDTH'(q);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_TICK_RATE:  tick_rate = value[RATE_W-1:0];
                CFG_MIN_PERIOD: min_period = value[LIMIT_W-1:0];
                CFG_MAX_PERIOD: max_period = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_op op, logic signed [SPEED_W-1:0] speed);
            int          s;
            int unsigned mag;
            int unsigned q;
            t_pin_state  e;
            s = int'(speed);
            case (op)
                OP_TICK: begin
                    if (tick_cnt >= period) begin
                        tick_cnt = '0;
                        step_pin = 1'b1;
                        position = dir_ccw ? position - 1 : position + 1;
                    end else if (tick_cnt == 1) begin
                        step_pin = 1'b0;
                        dir_pin  = dir_ccw;
                    end
                    tick_cnt = tick_cnt + 1'b1;
                end
                OP_SPEED: begin
                    dir_ccw = (s < 0);
                    mag = (s < 0) ? -s : s;
                    q = tick_rate / (mag + 1);
                    // when the limits cross, a quotient above max_period takes max_period, any other min_period
                    if (q > max_period) begin
                        q = max_period;
                    end else if (q < min_period) begin
                        q = min_period;
                    end
                    period = cap_period(q);
                end
                OP_ZERO: position = '0;
                OP_NONE: ;
                default: ;
            endcase
            e.step = step_pin;
            e.dir  = dir_pin;
            e.pos  = position;
            expected_pins.push_back(e);
        endfunction

        function void check_result(logic step, logic dir, logic [POS_W-1:0] pos);
            t_pin_state e;
            if (expected_pins.size() == 0) begin
                $display("%0t: unexpected transaction step %0b dir %0b pos %0d",
                         $time, step, dir, $signed(pos));
                errors++;
                return;
            end
            e = expected_pins.pop_front();
            if (step !== e.step) begin
                $display("%0t: step_level expected %0b actual %0b", $time, e.step, step);
                errors++;
            end
            if (dir !== e.dir) begin
                $display("%0t: dir_level expected %0b actual %0b", $time, e.dir, dir);
                errors++;
            end
            if (pos !== e.pos) begin
                $display("%0t: step_position expected %0d actual %0d",
                         $time, $signed(e.pos), $signed(pos));
                errors++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   sent_count;
    int   taken_count;
    int   quiet_cycles;
    step_scoreboard sb;

    ssdg_in_if  item_if ();
    ssdg_out_if result_if ();
    ssdg_cfg_if cfg_if ();

    stepper_step_dir_generator u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    always #1 clk = ~clk;

    task automatic send_item(input t_op op, input logic signed [SPEED_W-1:0] spd);
        int gap;
        gap = ((sent_count % 64) < 16) ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid         <= 1'b1;
        item_if.mode          <= op;
        item_if.speed_command <= spd;
        do @(posedge clk); while (!item_if.ready);
        sb.note_item(op, spd);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void random_command(output t_op op,
                                           output logic signed [SPEED_W-1:0] spd);
        int unsigned pick = $urandom_range(0, 99);
        int          m = $urandom_range(0, 300);
        if (pick < 70) begin
            op = OP_TICK;
        end else if (pick < 88) begin
            op = OP_SPEED;
        end else if (pick < 94) begin
            op = OP_ZERO;
        end else begin
            op = OP_NONE;
        end
        if ($urandom_range(0, 9) < 6) begin
            spd = SPEED_W'($urandom);
        end else begin
            spd = $urandom_range(0, 1) ? SPEED_W'(-m) : SPEED_W'(m);
        end
    endfunction

    task automatic run_phase(input int unsigned rate, input int unsigned lo,
                             input int unsigned hi);
        t_op                       op;
        logic signed [SPEED_W-1:0] spd;
        write_reg(CFG_TICK_RATE, CFG_W'(rate));
        write_reg(CFG_MIN_PERIOD, {1'($urandom), LIMIT_W'(lo)});
        write_reg(CFG_MAX_PERIOD, {1'($urandom), LIMIT_W'(hi)});
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        // zero speed and most negative speed under this setting
        send_item(OP_SPEED, '0);
        send_item(OP_TICK, '0);
        send_item(OP_SPEED, -SPEED_W'(1048576));
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        repeat (PHASE_ITEMS) begin
            random_command(op, spd);
            send_item(op, spd);
        end
        wait_idle();
    endtask

    // result side with random back-pressure
    initial begin
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            int stall;
            stall = ((taken_count % 50) < 12) ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                result_if.ready <= 1'b0;
                @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            sb.check_result(result_if.step_level, result_if.dir_level,
                            result_if.step_position);
            taken_count++;
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        rst_n                 = 1'b0;
        sent_count            = 0;
        taken_count           = 0;
        quiet_cycles          = 0;
        item_if.valid         = 1'b0;
        item_if.mode          = OP_TICK;
        item_if.speed_command = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = CFG_TICK_RATE;
        cfg_if.data           = '0;
        result_if.ready       = 1'b0;
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: falling step edge, unused mode, zero and extreme speeds
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        send_item(OP_NONE, 21'h155555);
        send_item(OP_SPEED, '0);
        send_item(OP_SPEED, SPEED_W'(1048575));
        repeat (3) send_item(OP_TICK, '0);
        send_item(OP_SPEED, -SPEED_W'(1048576));
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        // counter runs past a lowered period
        send_item(OP_SPEED, '0);
        repeat (6) send_item(OP_TICK, '0);
        send_item(OP_SPEED, SPEED_W'(100000));
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        send_item(OP_ZERO, '0);
        send_item(OP_ZERO, '1);
        send_item(OP_SPEED, -SPEED_W'(1048575));
        wait_idle();

        run_phase(1048575, 1, 524287);
        run_phase(1, 1, 1);
        // zero limits give a zero period
        run_phase(40, 0, 0);
        // crossed limits
        run_phase(300, 25, 4);
        run_phase($urandom_range(20, 2000), $urandom_range(1, 4), $urandom_range(5, 60));

        repeat (40) @(negedge clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
